// ===== hw/rtl/turing_machine_stepper_core_assert.svh =====
// Assertion macros used by the checker module of the Turing machine stepper.
// No dependencies; the including file supplies clock, reset and property text.
`ifndef TURING_MACHINE_STEPPER_CORE_ASSERT_SVH
`define TURING_MACHINE_STEPPER_CORE_ASSERT_SVH

// Property that is ignored while reset is held low.
`define TMS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property that must also hold across reset.
`define TMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hw/rtl/tms_pkg.sv =====
// Shared types, constants and helper functions of the Turing machine stepper.
// No dependencies; used by the core and the checker.
`timescale 1ns / 1ps

package tms_pkg;

    // Tape geometry and machine size.
    localparam int TAPE_BYTES  = 4096;
    localparam int TAPE_ADDR_W = $clog2(TAPE_BYTES);
    localparam int TAPE_BITS   = TAPE_BYTES * 8;
    localparam int NUM_STATES  = 8;

    localparam int HEAD_W  = 17;
    localparam int STATE_W = 4;
    localparam int COUNT_W = 40;
    localparam int START_W = 15;

    localparam logic [START_W-1:0] START_POS_RESET  = 15'd16384;
    localparam logic [COUNT_W-1:0] STEP_LIMIT_RESET = 40'd100000000;

    // Port widths.
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 80;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Bit positions of the result fields inside m_tdata.
    localparam int OUT_STATUS_LO = 0;
    localparam int OUT_STATE_LO  = 3;
    localparam int OUT_HEAD_LO   = 7;
    localparam int OUT_WROTE_BIT = 24;
    localparam int OUT_RIGHT_BIT = 25;
    localparam int OUT_DID_BIT   = 26;
    localparam int OUT_STEPS_LO  = 27;
    localparam int OUT_BYTE_LO   = 67;
    localparam int OUT_BYTE_HI   = 74;

    typedef enum logic [1:0] {
        ACT_STEP    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STOP_RUNNING = 3'd0,
        STOP_HALTED  = 3'd1,
        STOP_LIMIT   = 3'd2,
        STOP_LEFT    = 3'd3,
        STOP_RIGHT   = 3'd4
    } stop_t;

    typedef enum logic [1:0] {
        CFG_TRANS_LO   = 2'd0,
        CFG_TRANS_HI   = 2'd1,
        CFG_START_POS  = 2'd2,
        CFG_STEP_LIMIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_READ,
        SEQ_STEP
    } seq_t;

    typedef struct packed {
        stop_t                     run_status;
        logic [STATE_W-1:0]        current_state;
        logic signed [HEAD_W-1:0]  head_location;
        logic                      bit_written;
        logic                      moved_right;
        logic                      did_step;
        logic [COUNT_W-1:0]        steps_taken;
        logic [7:0]                tape_byte;
    } result_t;

    // Stop conditions in priority order: halt state, step limit, left edge, right edge.
    function automatic stop_t check_stop(
        input logic [STATE_W-1:0]       st,
        input logic [COUNT_W-1:0]       cnt,
        input logic [COUNT_W-1:0]       lim,
        input logic signed [HEAD_W-1:0] head
    );
        stop_t res;
        if (st >= STATE_W'(NUM_STATES)) begin
            res = STOP_HALTED;
        end else if (cnt >= lim) begin
            res = STOP_LIMIT;
        end else if (head[HEAD_W-1]) begin
            res = STOP_LEFT;
        end else if ($unsigned(head) >= HEAD_W'(TAPE_BITS)) begin
            res = STOP_RIGHT;
        end else begin
            res = STOP_RUNNING;
        end
        return res;
    endfunction

    // Picks table entry idx out of the two packed table registers.
    function automatic logic [7:0] table_entry(
        input logic [63:0] lo,
        input logic [63:0] hi,
        input logic [3:0]  idx
    );
        logic [63:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/tms_tape_ram.sv =====
// Simple dual-port RAM holding the bit-packed tape: one write and one read port.
// Generic; read data is registered, so it appears in the cycle after the read.
`timescale 1ns / 1ps

module tms_tape_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/turing_machine_stepper_core.sv =====
// Top level of the Turing machine stepper; uses tms_pkg and tms_tape_ram.
// Step: tape read at accept, then write-back in SEQ_STEP; no new transaction until SEQ_IDLE.
// Tape read: result staged from SEQ_READ; restart, unused action, step when stopped: at accept.
// Throughput is set by the single tape RAM read-modify-write per step.
// aresetn (synchronous, active low) restores the registers and starts a tape
// clearing pass over all tape bytes; a restart runs the same pass. No transaction is taken meanwhile.
`timescale 1ns / 1ps

module turing_machine_stepper_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tms_pkg::S_TDATA_W-1:0]   s_tdata,     // [11:0] byte_address, rest zero
    input  logic [tms_pkg::S_TUSER_W-1:0]   s_tuser,     // [1:0] action
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] run_status, [6:3] current_state, [23:7] head_location, [24] bit_written,
    // [25] moved_right, [26] did_step, [66:27] steps_taken, [74:67] tape_byte, rest zero
    output logic [tms_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [tms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    import tms_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land whenever cfg_wr_en is high;
    // the register index selects one of the four registers.
    // ------------------------------------------------------------------
    logic [63:0]        trans_lo_reg, trans_lo_next;
    logic [63:0]        trans_hi_reg, trans_hi_next;
    logic [START_W-1:0] start_pos_reg, start_pos_next;
    logic [COUNT_W-1:0] limit_reg, limit_next;

    always_comb begin
        trans_lo_next  = trans_lo_reg;
        trans_hi_next  = trans_hi_reg;
        start_pos_next = start_pos_reg;
        limit_next     = limit_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TRANS_LO:   trans_lo_next  = cfg_wr_data;
                CFG_TRANS_HI:   trans_hi_next  = cfg_wr_data;
                CFG_START_POS:  start_pos_next = cfg_wr_data[START_W-1:0];
                CFG_STEP_LIMIT: limit_next     = cfg_wr_data[COUNT_W-1:0];
                default:        trans_lo_next  = trans_lo_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Machine state. The tape itself lives in the RAM below; everything
    // else about the machine is held in these few registers.
    // ------------------------------------------------------------------
    logic signed [HEAD_W-1:0] head_reg, head_next;
    logic [STATE_W-1:0]       state_reg, state_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    stop_t                    stop_reg, stop_next;

    // Sequencer and tape clearing counter.
    seq_t                   seq_reg, seq_next;
    logic [TAPE_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                   rd_ok_reg, rd_ok_next;

    // Result staging: res_reg is a skid stage in front of the output register,
    // so a new transaction can be accepted while a result still waits.
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    // Input decode.
    action_t    action;
    logic [11:0] byte_address;
    logic       in_fire;
    logic       res_move;
    logic       clr_done;

    assign action       = action_t'(s_tuser);
    assign byte_address = s_tdata[11:0];
    assign res_move     = res_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready     = (seq_reg == SEQ_IDLE) && (!res_valid_reg || !m_valid_reg || m_tready);
    assign in_fire      = s_tvalid && s_tready;
    assign clr_done     = (clr_addr_reg == TAPE_ADDR_W'(TAPE_BYTES - 1));

    // Stop check on the present machine state, made when a step is accepted.
    stop_t cur_stop;
    logic  step_go;

    assign cur_stop = check_stop(state_reg, count_reg, limit_reg, head_reg);
    assign step_go  = in_fire && (action == ACT_STEP) && (stop_reg == STOP_RUNNING)
                      && (cur_stop == STOP_RUNNING);

    // ------------------------------------------------------------------
    // Step datapath. It works on the tape byte that was read at accept
    // time and is valid while the sequencer sits in SEQ_STEP.
    // ------------------------------------------------------------------
    logic [7:0]               ram_rdata;
    logic [2:0]               boff;
    logic                     tape_bit;
    logic [7:0]               entry;
    logic [7:0]               merged_byte;
    logic signed [HEAD_W-1:0] head_step;
    logic [STATE_W-1:0]       state_step;
    logic [COUNT_W-1:0]       count_step;
    stop_t                    stop_step;
    logic [TAPE_ADDR_W-1:0]   head_byte;

    assign boff        = head_reg[2:0];
    assign head_byte   = head_reg[TAPE_ADDR_W+2:3];
    assign tape_bit    = ram_rdata[boff];
    assign entry       = table_entry(trans_lo_reg, trans_hi_reg, {state_reg[2:0], tape_bit});
    assign merged_byte = (ram_rdata & ~(8'h01 << boff)) | ({7'd0, entry[0]} << boff);
    assign head_step   = entry[1] ? head_reg + 17'sd1 : head_reg - 17'sd1;
    assign state_step  = entry[5:2];
    assign count_step  = count_reg + 40'd1;
    assign stop_step   = check_stop(state_step, count_step, limit_reg, head_step);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_CLEAR: begin
                if (clr_done) begin
                    seq_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE: begin
                if (in_fire) begin
                    if (action == ACT_READ) begin
                        seq_next = SEQ_READ;
                    end else if (action == ACT_RESTART) begin
                        seq_next = SEQ_CLEAR;
                    end else if (step_go) begin
                        seq_next = SEQ_STEP;
                    end
                end
            end
            SEQ_READ: seq_next = SEQ_IDLE;
            SEQ_STEP: seq_next = SEQ_IDLE;
            default:  seq_next = SEQ_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: tape RAM control and result generation.
    // The RAM is read at the accept edge and, for a step, written back in the
    // following cycle. Only one transaction is in flight, so the next read of
    // the same byte always comes after the write-back and needs no bypass.
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic [TAPE_ADDR_W-1:0] ram_waddr;
    logic [7:0]             ram_wdata;
    logic                   ram_re;
    logic [TAPE_ADDR_W-1:0] ram_raddr;
    logic                   res_load;

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = clr_addr_reg;
        ram_wdata  = 8'h00;
        ram_re     = 1'b0;
        ram_raddr  = head_byte;
        rd_ok_next = rd_ok_reg;
        res_load   = 1'b0;

        res_next.run_status    = stop_reg;
        res_next.current_state = state_reg;
        res_next.head_location = head_reg;
        res_next.bit_written   = 1'b0;
        res_next.moved_right   = 1'b0;
        res_next.did_step      = 1'b0;
        res_next.steps_taken   = count_reg;
        res_next.tape_byte     = 8'h00;

        unique case (seq_reg)
            SEQ_CLEAR: begin
                ram_we = 1'b1;
            end
            SEQ_IDLE: begin
                if (in_fire) begin
                    case (action)
                        ACT_READ: begin
                            ram_re     = 1'b1;
                            ram_raddr  = byte_address[TAPE_ADDR_W-1:0];
                            rd_ok_next = ({1'b0, byte_address} < 13'(TAPE_BYTES));
                        end
                        ACT_STEP: begin
                            // A step that runs reads the byte under the head; one that
                            // finds the machine stopped reports at once.
                            ram_re   = step_go;
                            res_load = !step_go;
                            if (stop_reg == STOP_RUNNING) begin
                                res_next.run_status = cur_stop;
                            end
                        end
                        ACT_RESTART: begin
                            res_load               = 1'b1;
                            res_next.run_status    = STOP_RUNNING;
                            res_next.current_state = '0;
                            res_next.head_location = signed'({2'b00, start_pos_reg});
                            res_next.steps_taken   = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            SEQ_READ: begin
                res_load           = 1'b1;
                res_next.tape_byte = rd_ok_reg ? ram_rdata : 8'h00;
            end
            SEQ_STEP: begin
                ram_we                 = 1'b1;
                ram_waddr              = head_byte;
                ram_wdata              = merged_byte;
                res_load               = 1'b1;
                res_next.run_status    = stop_step;
                res_next.current_state = state_step;
                res_next.head_location = head_step;
                res_next.bit_written   = entry[0];
                res_next.moved_right   = entry[1];
                res_next.did_step      = 1'b1;
                res_next.steps_taken   = count_step;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Machine register updates.
    always_comb begin
        head_next     = head_reg;
        state_next    = state_reg;
        count_next    = count_reg;
        stop_next     = stop_reg;
        clr_addr_next = clr_addr_reg;

        if (seq_reg == SEQ_CLEAR) begin
            clr_addr_next = clr_addr_reg + TAPE_ADDR_W'(1);
        end

        if (in_fire && (action == ACT_STEP) && (stop_reg == STOP_RUNNING)) begin
            stop_next = cur_stop;
        end

        if (in_fire && (action == ACT_RESTART)) begin
            head_next     = signed'({2'b00, start_pos_reg});
            state_next    = '0;
            count_next    = '0;
            stop_next     = STOP_RUNNING;
            clr_addr_next = '0;
        end

        if (seq_reg == SEQ_STEP) begin
            head_next  = head_step;
            state_next = state_step;
            count_next = count_step;
            stop_next  = stop_step;
        end
    end

    // Skid stage and output register.
    always_comb begin
        res_valid_next = res_valid_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        if (!m_valid_reg || m_tready) begin
            m_valid_next = res_valid_reg;
            out_next     = res_reg;
        end
        if (res_move) begin
            res_valid_next = 1'b0;
        end
        if (res_load) begin
            res_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trans_lo_reg  <= '0;
            trans_hi_reg  <= '0;
            start_pos_reg <= START_POS_RESET;
            limit_reg     <= STEP_LIMIT_RESET;
            head_reg      <= signed'({2'b00, START_POS_RESET});
            state_reg     <= '0;
            count_reg     <= '0;
            stop_reg      <= STOP_RUNNING;
            seq_reg       <= SEQ_CLEAR;
            clr_addr_reg  <= '0;
            rd_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            trans_lo_reg  <= trans_lo_next;
            trans_hi_reg  <= trans_hi_next;
            start_pos_reg <= start_pos_next;
            limit_reg     <= limit_next;
            head_reg      <= head_next;
            state_reg     <= state_next;
            count_reg     <= count_next;
            stop_reg      <= stop_next;
            seq_reg       <= seq_next;
            clr_addr_reg  <= clr_addr_next;
            rd_ok_reg     <= rd_ok_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Result payload needs no reset; its valid flags qualify it.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_next;
        end
        out_reg <= out_next;
    end

    // ------------------------------------------------------------------
    // Tape memory: one byte per word, cleared by the sequencer sweep.
    // ------------------------------------------------------------------
    tms_tape_ram #(
        .DEPTH (TAPE_BYTES),
        .WIDTH (8)
    ) u_tape_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output packing, highest field first.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0,
                       out_reg.tape_byte,
                       out_reg.steps_taken,
                       out_reg.did_step,
                       out_reg.moved_right,
                       out_reg.bit_written,
                       out_reg.head_location,
                       out_reg.current_state,
                       out_reg.run_status};

endmodule

// ===== hw/rtl/tms_checker.sv =====
// Port-level checker for the Turing machine stepper, bound to the top level.
// Depends on tms_pkg and turing_machine_stepper_core_assert.svh.
`timescale 1ns / 1ps
`include "turing_machine_stepper_core_assert.svh"

module tms_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tms_pkg::M_TDATA_W-1:0] m_tdata
);

    import tms_pkg::*;

    // The result channel comes out of reset empty.
    `TMS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result keeps its payload.
    `TMS_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Without a step, no written bit and no move are reported.
    `TMS_ASSERT(a_nostep_quiet, aclk, aresetn, m_tvalid && !m_tdata[OUT_DID_BIT] |-> !m_tdata[OUT_WROTE_BIT] && !m_tdata[OUT_RIGHT_BIT], "move reported without a step")

    // A step transaction never carries tape read data.
    `TMS_ASSERT(a_step_no_byte, aclk, aresetn, m_tvalid && m_tdata[OUT_DID_BIT] |-> m_tdata[OUT_BYTE_HI:OUT_BYTE_LO] == 8'h00, "tape byte on a step result")

endmodule

bind turing_machine_stepper_core tms_checker u_tms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
